// ----- sv/srrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region range table: shared package
// Sizes, opcode and status codes, entry layout and compare result type.
// ----------------------------------------------------------------------------
package srrt_pkg;

  localparam int TABLE_DEPTH      = 64;
  localparam int ADDR_WIDTH       = 48;
  localparam int SMALL_SPAN_LOG2  = 16;
  localparam int MEDIUM_SPAN_LOG2 = 20;

  localparam int KIND_WIDTH = 3;
  localparam int IDX_WIDTH  = $clog2(TABLE_DEPTH);
  localparam int CNT_WIDTH  = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [KIND_WIDTH-1:0] KIND_MEDIUM = 3'd5;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] base;
    logic [KIND_WIDTH-1:0] kind;
  } entry_t;

  // Outcome of comparing the request address against one stored entry.
  typedef struct packed {
    logic below;   // address below entry base
    logic equal;   // address equals entry base
    logic beyond;  // address at or past the end of the entry's span
  } cmp_res_t;

endpackage

// ----- sv/srrt_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srrt_mem
  import srrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_WIDTH-1:0] waddr,
  input  entry_t               wdata,
  input  logic [IDX_WIDTH-1:0] raddr,
  output entry_t               rdata
);

  entry_t ram_r [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
    rdata_r <= ram_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/srrt_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared address compare unit
// One subtract classifies the address against an entry's base and span.
// ----------------------------------------------------------------------------
module srrt_cmp
  import srrt_pkg::*;
(
  input  logic [ADDR_WIDTH-1:0] addr,
  input  entry_t                entry,
  output cmp_res_t              res
);

  logic [ADDR_WIDTH:0]   diff;
  logic [ADDR_WIDTH-1:0] offs;
  logic                  is_medium;

  assign diff      = {1'b0, addr} - {1'b0, entry.base};
  assign offs      = diff[ADDR_WIDTH-1:0];
  assign is_medium = (entry.kind == KIND_MEDIUM);

  always_comb begin
    res.below = diff[ADDR_WIDTH];
    res.equal = (diff == '0);
    // offset past the span: any bit at or above the span's log2 is set
    if (is_medium) begin
      res.beyond = ((offs >> MEDIUM_SPAN_LOG2) != '0);
    end else begin
      res.beyond = ((offs >> SMALL_SPAN_LOG2) != '0);
    end
  end

endmodule

// ----- sv/sorted_region_range_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region range table core
// Keeps region entries sorted by base; insert, remove and find by address.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with in_op, in_addr and in_kind while
//   busy is low; the request is taken at that clock edge. Ops: insert a region,
//   remove a region by exact base, find the region whose span holds in_addr.
//   Every request yields one result, shown for exactly one cycle with out_valid
//   high: status, found base and kind (zero unless a find hits) and the entry
//   count after the request. The receiver cannot stall; sample on out_valid.
// Operation:
//   Each binary-search probe uses the single memory read port: a read, then a
//   compare in the shared compare unit. A find or the search part of an insert
//   or remove makes at most 7 probes for 64 entries.
//   Insert then moves each later entry up, one read and one write per entry,
//   then writes the new entry; remove moves each later entry down likewise.
//   An insert into a full table and a reserved op are answered from idle.
//   busy stays low for those, else high for the request; one request at a time.
// Reset:
//   rst_n low (synchronous) empties the table and drops any request in flight.
//   Stored entries need no clearing: only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_region_range_table_core
  import srrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [ADDR_WIDTH-1:0] in_addr,
  input  logic [KIND_WIDTH-1:0] in_kind,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [ADDR_WIDTH-1:0] out_found_base,
  output logic [KIND_WIDTH-1:0] out_found_kind,
  output logic [CNT_WIDTH-1:0]  out_entries_in_use
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WR
  } state_t;

  state_t                state_r;
  logic [1:0]            op_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [KIND_WIDTH-1:0] kind_r;
  logic [CNT_WIDTH-1:0]  count_r;
  logic [CNT_WIDTH-1:0]  lo_r;
  logic [CNT_WIDTH-1:0]  hi_r;   // exclusive upper bound of the search window
  logic [CNT_WIDTH-1:0]  mid_r;
  logic [CNT_WIDTH-1:0]  ptr_r;  // shift cursor

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [ADDR_WIDTH-1:0] out_base_r;
  logic [KIND_WIDTH-1:0] out_kind_r;
  logic [CNT_WIDTH-1:0]  out_count_r;

  logic [CNT_WIDTH:0]    sum_w;
  logic [CNT_WIDTH-1:0]  mid_w;
  logic [KIND_WIDTH-1:0] kind_w;

  logic                  mem_we;
  logic [IDX_WIDTH-1:0]  mem_waddr;
  entry_t                mem_wdata;
  logic [IDX_WIDTH-1:0]  mem_raddr;
  entry_t                mem_rdata;
  cmp_res_t              cmp;

  // Insert rounds the midpoint down over [lo, hi); remove and find follow
  // the inclusive form, whose midpoint is floor((lo + hi - 1) / 2).
  assign sum_w = {1'b0, lo_r} + {1'b0, hi_r};
  always_comb begin
    if (op_r == OP_INSERT) begin
      mid_w = sum_w[CNT_WIDTH:1];
    end else begin
      mid_w = CNT_WIDTH'((sum_w - 1'b1) >> 1);
    end
  end

  // Clamp out-of-range kinds to medium.
  assign kind_w = (in_kind > KIND_MEDIUM) ? KIND_MEDIUM : in_kind;

  // Memory port steering per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r[IDX_WIDTH-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = mid_w[IDX_WIDTH-1:0];
    unique case (state_r)
      S_INS_RD: begin
        mem_raddr = IDX_WIDTH'(ptr_r - 1'b1);
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_INS_PUT: begin
        mem_we         = 1'b1;
        mem_waddr      = lo_r[IDX_WIDTH-1:0];
        mem_wdata.base = addr_r;
        mem_wdata.kind = kind_r;
      end
      S_REM_RD: begin
        mem_raddr = IDX_WIDTH'(ptr_r + 1'b1);
      end
      S_REM_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  srrt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srrt_cmp u_cmp (
    .addr  (addr_r),
    .entry (mem_rdata),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      op_r         <= OP_INSERT;
      out_status_r <= ST_OK;
      out_base_r   <= '0;
      out_kind_r   <= '0;
      out_count_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      out_base_r  <= '0;
      out_kind_r  <= '0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            addr_r <= in_addr;
            kind_r <= kind_w;
            lo_r   <= '0;
            hi_r   <= count_r;
            if (in_op == OP_INSERT && count_r == CNT_WIDTH'(TABLE_DEPTH)) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FULL;
              out_count_r  <= count_r;
            end else if (in_op == OP_INSERT || in_op == OP_REMOVE ||
                         in_op == OP_FIND) begin
              state_r <= S_PROBE;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_MISS;
              out_count_r  <= count_r;
            end
          end
        end
        S_PROBE: begin
          if (lo_r < hi_r) begin
            // read issued at mid_w; compare next cycle
            mid_r   <= mid_w;
            state_r <= S_CMP;
          end else if (op_r == OP_INSERT) begin
            ptr_r <= count_r;
            if (count_r == lo_r) begin
              state_r <= S_INS_PUT;
            end else begin
              state_r <= S_INS_RD;
            end
          end else begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_MISS;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        S_CMP: begin
          state_r <= S_PROBE;
          if (op_r == OP_INSERT) begin
            if (!cmp.below && !cmp.equal) begin
              lo_r <= mid_r + 1'b1;
            end else begin
              hi_r <= mid_r;
            end
          end else if (op_r == OP_REMOVE) begin
            if (cmp.equal) begin
              ptr_r <= mid_r;
              if (mid_r + 1'b1 == count_r) begin
                count_r      <= count_r - 1'b1;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_OK;
                out_count_r  <= count_r - 1'b1;
                state_r      <= S_IDLE;
              end else begin
                state_r <= S_REM_RD;
              end
            end else if (!cmp.below) begin
              lo_r <= mid_r + 1'b1;
            end else begin
              hi_r <= mid_r;
            end
          end else begin
            if (cmp.below) begin
              hi_r <= mid_r;
            end else if (cmp.beyond) begin
              lo_r <= mid_r + 1'b1;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_OK;
              out_base_r   <= mem_rdata.base;
              out_kind_r   <= mem_rdata.kind;
              out_count_r  <= count_r;
              state_r      <= S_IDLE;
            end
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_WR;
        end
        S_INS_WR: begin
          // entry at ptr-1 moved up to ptr; advance down
          ptr_r <= ptr_r - 1'b1;
          if (ptr_r - 1'b1 == lo_r) begin
            state_r <= S_INS_PUT;
          end else begin
            state_r <= S_INS_RD;
          end
        end
        S_INS_PUT: begin
          count_r      <= count_r + 1'b1;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_count_r  <= count_r + 1'b1;
          state_r      <= S_IDLE;
        end
        S_REM_RD: begin
          state_r <= S_REM_WR;
        end
        S_REM_WR: begin
          // entry at ptr+1 moved down to ptr; advance up
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r + 2'd2 == count_r) begin
            count_r      <= count_r - 1'b1;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_count_r  <= count_r - 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_REM_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_base     = out_base_r;
  assign out_found_kind     = out_kind_r;
  assign out_entries_in_use = out_count_r;

  // Entry count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_WIDTH'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // A compare only happens on a non-empty search window.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (lo_r <= mid_r && mid_r < hi_r))
    else $error("probe outside search window");

  // A full report only comes from a full table.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> count_r == CNT_WIDTH'(TABLE_DEPTH))
    else $error("full reported on a table with room");

  // Only a hit carries base and kind.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> (out_base_r == '0 && out_kind_r == '0))
    else $error("found fields set without a hit");

  // Shifting up never writes at or below the insert slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_WR |-> ptr_r > lo_r)
    else $error("insert shift below slot");

endmodule
